>>> hdl/fcalc_pkg.sv
// Shared types and constants for the calculator key sequencer.
`default_nettype none
package fcalc_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int PC_W = 5;

	localparam logic [1:0] ACT_DIGIT = 2'd0;
	localparam logic [1:0] ACT_OPER  = 2'd1;
	localparam logic [1:0] ACT_EQ    = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef enum logic [3:0] {
		U_NOP,
		U_SHOW_ENT,
		U_DIGIT,
		U_OPR_COMMIT,
		U_ARITH_LOAD,
		U_MUL_STEP,
		U_MUL_DONE,
		U_DIV_INIT,
		U_DIV_STEP,
		U_DIV_DONE,
		U_EQ_COMMIT,
		U_EMIT
	} fcalc_uop_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_NO_KEY,
		C_DIGIT,
		C_OPER,
		C_EQ,
		C_NO_APPLY,
		C_OP_MUL,
		C_OP_DIV,
		C_BZERO,
		C_CNT_MORE,
		C_OUT_BUSY
	} fcalc_cond_t;

	typedef struct packed {
		fcalc_uop_t        uop;
		fcalc_cond_t       cond;
		logic [PC_W-1:0]   tgt;
	} fcalc_cw_t;

	typedef struct packed {
		logic is_digit;
		logic is_oper;
		logic is_eq;
		logic no_apply;
		logic op_mul;
		logic op_div;
		logic b_zero;
		logic cnt_more;
		logic out_busy;
	} fcalc_stat_t;

endpackage
`default_nettype wire

>>> hdl/four_function_calculator_keys_top.sv
// Top level of the left-to-right four-function calculator key processor.
// Usage:
//   Keys enter on the s_ stream: s_tuser carries the key kind (digit,
//   operator, equals), s_tdata the digit and operator code. Each key gives
//   one item on the m_ stream: the signed value to show in m_tdata and the
//   divide-by-zero flag in m_tuser.
//   One key is worked at a time; s_tready is high only while the sequencer
//   waits at its idle step, to which it returns only after the key's result
//   issues. A multiply runs VALUE_WIDTH shift-add steps; a divide runs
//   VALUE_WIDTH restoring steps unless the divisor is zero. Both units work
//   one bit per cycle, and these keys take the longest.
//   A result waits in the output register while m_tready is low; the next
//   key may be accepted meanwhile, and its result holds at the last step
//   until the register is free.
//   Reset clears the calculator state to zero with no operator pending,
//   and empties the output register.
`default_nettype none
module four_function_calculator_keys_top #(
	parameter int VALUE_WIDTH = fcalc_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [3:0] digit, [5:4] operator_code, [7:6] zero
	input  wire logic [1:0]  s_tuser,  // [1:0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [31:0] display_value
	output logic [0:0]       m_tuser   // [0] divide_by_zero
);
	import fcalc_pkg::*;

	fcalc_uop_t  uop;
	fcalc_stat_t stat;
	logic        idle;
	logic        flag;

	assign s_tready   = idle;
	assign m_tuser[0] = flag;

	fcalc_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (s_tvalid),
		.stat      (stat),
		.uop       (uop),
		.idle      (idle)
	);

	fcalc_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_fire   (s_tvalid && idle),
		.key_action (s_tuser),
		.key_digit  (s_tdata[3:0]),
		.key_op     (s_tdata[5:4]),
		.uop        (uop),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_flag   (flag)
	);

endmodule
`default_nettype wire

>>> hdl/fcalc_useq.sv
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none
module fcalc_useq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                key_valid,
	input  wire fcalc_pkg::fcalc_stat_t stat,
	output fcalc_pkg::fcalc_uop_t    uop,
	output logic                     idle
);
	import fcalc_pkg::*;

	localparam logic [PC_W-1:0] P_IDLE     = PC_W'(0);
	localparam logic [PC_W-1:0] P_DIG      = PC_W'(5);
	localparam logic [PC_W-1:0] P_OPR      = PC_W'(6);
	localparam logic [PC_W-1:0] P_OPR_FIN  = PC_W'(8);
	localparam logic [PC_W-1:0] P_EQ       = PC_W'(9);
	localparam logic [PC_W-1:0] P_ARITH    = PC_W'(10);
	localparam logic [PC_W-1:0] P_MUL      = PC_W'(13);
	localparam logic [PC_W-1:0] P_DIV      = PC_W'(15);
	localparam logic [PC_W-1:0] P_DIV_LOOP = PC_W'(16);
	localparam logic [PC_W-1:0] P_END      = PC_W'(18);
	localparam logic [PC_W-1:0] P_EQ_FIN   = PC_W'(20);
	localparam logic [PC_W-1:0] P_EMIT     = PC_W'(21);

	function automatic fcalc_cw_t rom_word(input logic [PC_W-1:0] a);
		fcalc_cw_t w;
		w = '{U_NOP, C_ALWAYS, P_IDLE};
		case (a)
			5'd0:  w = '{U_NOP,        C_NO_KEY,   P_IDLE};
			5'd1:  w = '{U_NOP,        C_DIGIT,    P_DIG};
			5'd2:  w = '{U_NOP,        C_OPER,     P_OPR};
			5'd3:  w = '{U_NOP,        C_EQ,       P_EQ};
			5'd4:  w = '{U_SHOW_ENT,   C_ALWAYS,   P_EMIT};
			5'd5:  w = '{U_DIGIT,      C_ALWAYS,   P_EMIT};
			5'd6:  w = '{U_NOP,        C_NO_APPLY, P_OPR_FIN};
			5'd7:  w = '{U_NOP,        C_ALWAYS,   P_ARITH};
			5'd8:  w = '{U_OPR_COMMIT, C_ALWAYS,   P_EMIT};
			5'd9:  w = '{U_NOP,        C_NO_APPLY, P_EQ_FIN};
			5'd10: w = '{U_ARITH_LOAD, C_OP_MUL,   P_MUL};
			5'd11: w = '{U_NOP,        C_OP_DIV,   P_DIV};
			5'd12: w = '{U_NOP,        C_ALWAYS,   P_END};
			5'd13: w = '{U_MUL_STEP,   C_CNT_MORE, P_MUL};
			5'd14: w = '{U_MUL_DONE,   C_ALWAYS,   P_END};
			5'd15: w = '{U_DIV_INIT,   C_BZERO,    P_END};
			5'd16: w = '{U_DIV_STEP,   C_CNT_MORE, P_DIV_LOOP};
			5'd17: w = '{U_DIV_DONE,   C_ALWAYS,   P_END};
			5'd18: w = '{U_NOP,        C_EQ,       P_EQ_FIN};
			5'd19: w = '{U_NOP,        C_ALWAYS,   P_OPR_FIN};
			5'd20: w = '{U_EQ_COMMIT,  C_ALWAYS,   P_EMIT};
			5'd21: w = '{U_EMIT,       C_OUT_BUSY, P_EMIT};
			default: w = '{U_NOP,      C_ALWAYS,   P_IDLE};
		endcase
		return w;
	endfunction

	logic [PC_W-1:0] pc_q;
	fcalc_cw_t       cw;
	logic            take;

	assign cw   = rom_word(pc_q);
	assign uop  = cw.uop;
	assign idle = (pc_q == P_IDLE);

	always_comb begin
		unique case (cw.cond)
			C_ALWAYS:   take = 1'b1;
			C_NO_KEY:   take = !key_valid;
			C_DIGIT:    take = stat.is_digit;
			C_OPER:     take = stat.is_oper;
			C_EQ:       take = stat.is_eq;
			C_NO_APPLY: take = stat.no_apply;
			C_OP_MUL:   take = stat.op_mul;
			C_OP_DIV:   take = stat.op_div;
			C_BZERO:    take = stat.b_zero;
			C_CNT_MORE: take = stat.cnt_more;
			C_OUT_BUSY: take = stat.out_busy;
			default:    take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			pc_q <= take ? cw.tgt : pc_q + PC_W'(1);
		end
	end

endmodule
`default_nettype wire

>>> hdl/fcalc_dp.sv
// Datapath: calculator state, shift-add multiplier, restoring divider, output register.
`default_nettype none
module fcalc_dp #(
	parameter int VALUE_WIDTH = fcalc_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   key_fire,
	input  wire logic [1:0]             key_action,
	input  wire logic [3:0]             key_digit,
	input  wire logic [1:0]             key_op,
	input  wire fcalc_pkg::fcalc_uop_t  uop,
	output fcalc_pkg::fcalc_stat_t      stat,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [31:0]                 out_value,
	output logic                        out_flag
);
	import fcalc_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic [1:0]   kact_q;
	logic [3:0]   kdig_q;
	logic [1:0]   kop_q;
	logic [W-1:0] acc_q, ent_q;
	logic [1:0]   pop_q;
	logic         opp_q, closed_q, present_q, zds_q;
	logic [W-1:0] a_q, b_q, p_q, t_q, sh_q;
	logic         neg_q, fl_q;
	logic [CW-1:0] cnt_q;
	logic         mv_q;
	logic [31:0]  md_q;
	logic         mf_q;

	logic         applied;
	logic [W-1:0] ent_next, addsub;
	logic [W:0]   rs, diff;
	logic         busy;
	logic [W+31:0] sh_ext;

	assign applied  = present_q && opp_q;
	assign busy     = mv_q && !out_ready;
	assign ent_next = closed_q ? W'(kdig_q)
		: (ent_q << 3) + (ent_q << 1) + W'(kdig_q);
	assign addsub   = (pop_q == OP_SUB) ? acc_q - ent_q : acc_q + ent_q;
	assign rs       = {p_q, a_q[W-1]};
	assign diff     = rs - {1'b0, b_q};
	assign sh_ext   = {{32{sh_q[W-1]}}, sh_q};

	assign stat.is_digit = (kact_q == ACT_DIGIT);
	assign stat.is_oper  = (kact_q == ACT_OPER);
	assign stat.is_eq    = (kact_q == ACT_EQ);
	assign stat.no_apply = !applied;
	assign stat.op_mul   = (pop_q == OP_MUL);
	assign stat.op_div   = (pop_q == OP_DIV);
	assign stat.b_zero   = (b_q == '0);
	assign stat.cnt_more = (cnt_q != CW'(1));
	assign stat.out_busy = busy;

	assign out_valid = mv_q;
	assign out_value = md_q;
	assign out_flag  = mf_q;

	always_ff @(posedge clk) begin
		if (key_fire) begin
			kact_q <= key_action;
			kdig_q <= key_digit;
			kop_q  <= key_op;
		end
		unique case (uop)
			U_SHOW_ENT: begin
				sh_q <= ent_q;
				fl_q <= 1'b0;
			end
			U_DIGIT: begin
				sh_q <= ent_next;
				fl_q <= 1'b0;
			end
			U_OPR_COMMIT: begin
				sh_q <= ent_q;
				fl_q <= 1'b0;
			end
			U_ARITH_LOAD: begin
				a_q   <= acc_q;
				b_q   <= ent_q;
				p_q   <= '0;
				cnt_q <= CW'(W);
				t_q   <= addsub;
			end
			U_MUL_STEP: begin
				if (a_q[0]) begin
					p_q <= p_q + b_q;
				end
				a_q   <= a_q >> 1;
				b_q   <= b_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end
			U_MUL_DONE: begin
				t_q <= p_q;
			end
			U_DIV_INIT: begin
				t_q   <= '0;
				neg_q <= a_q[W-1] ^ b_q[W-1];
				a_q   <= a_q[W-1] ? -a_q : a_q;
				b_q   <= b_q[W-1] ? -b_q : b_q;
				p_q   <= '0;
			end
			U_DIV_STEP: begin
				if (!diff[W]) begin
					p_q <= diff[W-1:0];
				end else begin
					p_q <= rs[W-1:0];
				end
				a_q   <= {a_q[W-2:0], !diff[W]};
				cnt_q <= cnt_q - CW'(1);
			end
			U_DIV_DONE: begin
				t_q <= neg_q ? -a_q : a_q;
			end
			U_EQ_COMMIT: begin
				if (applied) begin
					sh_q <= t_q;
				end else if (opp_q) begin
					sh_q <= acc_q;
				end else if (present_q) begin
					sh_q <= ent_q;
				end else begin
					sh_q <= '0;
				end
				fl_q <= zds_q;
			end
			U_EMIT: begin
				if (!busy) begin
					md_q <= sh_ext[31:0];
					mf_q <= fl_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			ent_q     <= '0;
			pop_q     <= OP_ADD;
			opp_q     <= 1'b0;
			closed_q  <= 1'b1;
			present_q <= 1'b0;
			zds_q     <= 1'b0;
			mv_q      <= 1'b0;
		end else begin
			if (uop == U_EMIT && !busy) begin
				mv_q <= 1'b1;
			end else if (out_ready) begin
				mv_q <= 1'b0;
			end
			unique case (uop)
				U_DIGIT: begin
					ent_q     <= ent_next;
					closed_q  <= 1'b0;
					present_q <= 1'b1;
				end
				U_OPR_COMMIT: begin
					if (applied) begin
						acc_q <= t_q;
					end else if (present_q) begin
						acc_q <= ent_q;
					end else if (!opp_q) begin
						acc_q <= '0;
					end
					pop_q     <= kop_q;
					opp_q     <= 1'b1;
					closed_q  <= 1'b1;
					present_q <= 1'b0;
				end
				U_DIV_INIT: begin
					if (b_q == '0) begin
						zds_q <= 1'b1;
					end
				end
				U_EQ_COMMIT: begin
					acc_q     <= '0;
					ent_q     <= '0;
					pop_q     <= OP_ADD;
					opp_q     <= 1'b0;
					closed_q  <= 1'b1;
					present_q <= 1'b0;
					zds_q     <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/fcalc_chk.sv
// Port checker for the calculator key processor, with its bind.
`default_nettype none
module fcalc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_one_key: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second key taken while one is at work");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result item appeared the cycle after its key");

	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready)
		else $error("result item issued while sequencer idle");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result item valid during reset");

endmodule

bind four_function_calculator_keys_top fcalc_chk u_fcalc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the left-to-right four-function calculator key processor.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fcalc_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned KEY_TARGET = 1850;

	typedef struct {
		logic [31:0] value;
		logic        zdiv;
	} shown_t;

	class display_board;
		logic [31:0] acc;
		logic [31:0] ent;
		logic [1:0]  pend_op;
		bit          op_pend;
		bit          ent_closed;
		bit          ent_present;
		bit          zdiv_seen;
		shown_t      display_q[$];
		int unsigned errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			acc = '0;
			ent = '0;
			pend_op = OP_ADD;
			op_pend = 0;
			ent_closed = 1;
			ent_present = 0;
			zdiv_seen = 0;
		endfunction

		function logic [31:0] fold(logic [31:0] a, logic [1:0] opc, logic [31:0] b);
			logic [31:0] ma;
			logic [31:0] mb;
			logic [31:0] q;
			case (opc)
				OP_ADD: return a + b;
				OP_SUB: return a - b;
				OP_MUL: return a * b;
				default: begin
					if (b == '0) begin
						zdiv_seen = 1;
						return '0;
					end
					ma = a[31] ? -a : a;
					mb = b[31] ? -b : b;
					q = ma / mb;
					return (a[31] ^ b[31]) ? -q : q;
				end
			endcase
		endfunction

		function void note_key(logic [1:0] act, logic [3:0] dig, logic [1:0] opc);
			shown_t exp_item;
			logic [31:0] res;
			exp_item.zdiv = 1'b0;
			case (act)
				ACT_DIGIT: begin
					if (ent_closed) begin
						ent = {28'd0, dig};
						ent_closed = 0;
					end else begin
						ent = ent * 32'd10 + {28'd0, dig};
					end
					ent_present = 1;
					exp_item.value = ent;
				end
				ACT_OPER: begin
					if (ent_present) begin
						acc = op_pend ? fold(acc, pend_op, ent) : ent;
					end else if (!op_pend) begin
						acc = '0;
					end
					pend_op = opc;
					op_pend = 1;
					ent_closed = 1;
					ent_present = 0;
					exp_item.value = ent;
				end
				ACT_EQ: begin
					if (op_pend)
						res = ent_present ? fold(acc, pend_op, ent) : acc;
					else
						res = ent_present ? ent : '0;
					exp_item.value = res;
					exp_item.zdiv = zdiv_seen;
					clear();
				end
				default: begin
					exp_item.value = ent;
				end
			endcase
			display_q.insert(display_q.size(), exp_item);
		endfunction

		function void check_display(logic [31:0] value, logic zdiv);
			shown_t exp_item;
			if (display_q.size() == 0) begin
				$display("%0t: unexpected item: display %0d flag %0b", $time,
					$signed(value), zdiv);
				errors++;
				return;
			end
			exp_item = display_q.pop_front();
			if (value !== exp_item.value) begin
				$display("%0t: display_value mismatch: expected %0d actual %0d", $time,
					$signed(exp_item.value), $signed(value));
				errors++;
			end
			if (zdiv !== exp_item.zdiv) begin
				$display("%0t: divide_by_zero mismatch: expected %0b actual %0b", $time,
					exp_item.zdiv, zdiv);
				errors++;
			end
		endfunction

		function int unsigned waiting();
			return display_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	display_board board = new();
	int unsigned  keys_sent = 0;
	bit           tx_calm = 0;
	bit           rx_calm = 0;
	bit           rx_hold_req = 0;
	bit           rx_hold_done = 0;

	four_function_calculator_keys_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic press(input logic [1:0] act, input logic [3:0] dig, input logic [1:0] opc);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {2'b00, opc, dig};
		do @(posedge clk); while (!s_tready);
		board.note_key(act, dig, opc);
		if (act != ACT_NONE)
			keys_sent++;
	endtask

	task automatic key_digit(input logic [3:0] dig);
		press(ACT_DIGIT, dig, 2'($urandom_range(0, 3)));
	endtask

	task automatic key_op(input logic [1:0] opc);
		press(ACT_OPER, 4'($urandom_range(0, 15)), opc);
	endtask

	task automatic key_eq();
		press(ACT_EQ, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
	endtask

	task automatic key_number(input logic [31:0] n);
		logic [3:0] digs[$];
		logic [31:0] rest;
		rest = n;
		do begin
			digs.push_front(4'(rest % 10));
			rest = rest / 10;
		end while (rest != 0);
		if ($urandom_range(0, 9) == 0)
			digs.push_front(4'd0);
		foreach (digs[i])
			key_digit(digs[i]);
	endtask

	// most negative value divided by minus one
	task automatic min_by_minus_one();
		key_op(OP_SUB);
		key_number(32'd2147483648);
		key_op(OP_DIV);
		key_number(32'hFFFFFFFF);
		key_eq();
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($urandom_range(0, 99));
			4, 5:       return 32'($urandom_range(0, 99999));
			6, 7:       return $urandom;
			8: begin
				case ($urandom_range(0, 4))
					0: return 32'd0;
					1: return 32'd1;
					2: return 32'h7FFFFFFF;
					3: return 32'h80000000;
					default: return 32'hFFFFFFFF;
				endcase
			end
			default: return 32'($urandom_range(0, 9));
		endcase
	endfunction

	task automatic run_expression();
		int unsigned n_operands;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3))
				press(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
					2'($urandom_range(0, 3)));
		end
		if ($urandom_range(0, 7) == 0)
			key_op(2'($urandom_range(0, 3)));
		n_operands = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
		for (int i = 0; i < n_operands; i++) begin
			key_number(pick_operand());
			if ($urandom_range(0, 19) == 0)
				press(ACT_NONE, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
			if (i < n_operands - 1 || $urandom_range(0, 7) == 0) begin
				key_op(2'($urandom_range(0, 3)));
				if ($urandom_range(0, 9) == 0)
					key_op(2'($urandom_range(0, 3)));
			end
		end
		key_eq();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		key_eq();
		key_op(OP_ADD);
		key_digit(4'd7);
		key_op(OP_MUL);
		key_eq();
		key_digit(4'd9);
		key_op(OP_ADD);
		key_op(OP_MUL);
		key_digit(4'd15);
		key_eq();
		key_digit(4'd5);
		key_op(OP_DIV);
		key_digit(4'd0);
		press(ACT_NONE, 4'd10, OP_SUB);
		key_eq();
		key_digit(4'd0);
		key_op(OP_SUB);
		key_digit(4'd7);
		key_op(OP_DIV);
		key_digit(4'd2);
		key_eq();
		key_digit(4'd4);
		key_digit(4'd2);
		key_eq();

		min_by_minus_one();
		while (keys_sent < KEY_TARGET) begin
			if (keys_sent % 64 < 8)
				tx_calm = ($urandom_range(0, 3) == 0);
			if (keys_sent > 700 && !rx_hold_done) begin
				rx_hold_req = 1;
				rx_hold_done = 1;
			end
			if ($urandom_range(0, 49) == 0)
				min_by_minus_one();
			else
				run_expression();
		end
		s_tvalid <= 1'b0;

		while (board.waiting() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int unsigned gap;
		int unsigned n_rx;
		n_rx = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (n_rx % 64 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			gap = rx_calm ? 0 : $urandom_range(0, 16);
			if (rx_hold_req) begin
				rx_hold_req = 0;
				gap = LONG_HOLD;
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_display(m_tdata, m_tuser[0]);
			n_rx++;
		end
	end

	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
